FILE: hdl/cpd_pkg.sv
// Shared constants, field codes and the result word type of the context packet deframer.
// No dependencies; every module of the deframer imports this package.
`default_nettype none

package cpd_pkg;

  // Layout limits
  localparam int unsigned DataBytes      = 140;
  localparam int unsigned MaxHeaderExtra = 16;
  localparam int unsigned MaxBricks      = 16;
  localparam int unsigned MaxDataExtra   = 16;

  localparam int unsigned IdBytes   = 16;
  localparam int unsigned AddrBytes = 4;
  localparam int unsigned PortBytes = 2;

  localparam int unsigned CODE_W = 5;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OFS_W  = 11;

  // Field codes, which double as parser phase codes
  localparam logic [CODE_W-1:0] FC_SERVICE     = 5'd0;
  localparam logic [CODE_W-1:0] FC_VERSION     = 5'd1;
  localparam logic [CODE_W-1:0] FC_CHANNEL     = 5'd2;
  localparam logic [CODE_W-1:0] FC_HDR_EXT_LEN = 5'd3;
  localparam logic [CODE_W-1:0] FC_ID          = 5'd4;
  localparam logic [CODE_W-1:0] FC_ADDR        = 5'd5;
  localparam logic [CODE_W-1:0] FC_PORT        = 5'd6;
  localparam logic [CODE_W-1:0] FC_HDR_EXT     = 5'd7;
  localparam logic [CODE_W-1:0] FC_CTX_TYPE    = 5'd8;
  localparam logic [CODE_W-1:0] FC_FIRST_CTX   = 5'd9;
  localparam logic [CODE_W-1:0] FC_FIRST_MASK  = 5'd10;
  localparam logic [CODE_W-1:0] FC_BRICK_CNT   = 5'd11;
  localparam logic [CODE_W-1:0] FC_BRICK_CTX   = 5'd12;
  localparam logic [CODE_W-1:0] FC_BRICK_MASK  = 5'd13;
  localparam logic [CODE_W-1:0] FC_DATA_TYPE   = 5'd14;
  localparam logic [CODE_W-1:0] FC_DATA        = 5'd15;
  localparam logic [CODE_W-1:0] FC_DATA_EXT_LEN = 5'd16;
  localparam logic [CODE_W-1:0] FC_DATA_EXT    = 5'd17;

  typedef struct packed {
    logic              size_over_limit;
    logic              packet_end;
    logic [OFS_W-1:0]  byte_offset;
    logic [BYTE_W-1:0] byte_value;
    logic [IDX_W-1:0]  field_index;
    logic [CODE_W-1:0] field_code;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/cpd_in_stage.sv
// Input register of the context packet deframer: holds one received word.
// Depends on cpd_pkg for the byte width.
`default_nettype none

module cpd_in_stage
  import cpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [BYTE_W-1:0] s_tdata,
  output logic                   byte_valid,
  output logic [BYTE_W-1:0]      byte_data,
  input  wire logic              byte_take
);

  // accept whenever the held word is empty or leaves this cycle
  assign s_tready = !byte_valid || byte_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (s_tready) begin
      byte_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      byte_data <= s_tdata;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cpd_parser.sv
// Parse state and result register of the context packet deframer.
// Tags each held word with its field; depends on cpd_pkg.
`default_nettype none

module cpd_parser
  import cpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              byte_valid,
  input  wire logic [BYTE_W-1:0] byte_data,
  output logic                   byte_take,
  output logic                   res_valid,
  output result_t                res,
  input  wire logic              res_ready
);

  logic [CODE_W-1:0] phase;
  logic [CODE_W-1:0] phase_next;
  logic [IDX_W-1:0]  cnt;
  logic [IDX_W-1:0]  cnt_next;
  logic [BYTE_W-1:0] hdr_ext_len;
  logic [BYTE_W-1:0] brick_total;
  logic [BYTE_W-1:0] data_ext_len;
  logic [OFS_W-1:0]  offset;

  logic [CODE_W-1:0] ph;
  logic [IDX_W:0]    cnt_inc;
  logic [IDX_W-1:0]  idx;
  logic              over;
  logic              done;

  assign byte_take = byte_valid && (!res_valid || res_ready);

  always_comb begin
    ph       = (phase > FC_DATA_EXT) ? FC_SERVICE : phase;
    cnt_inc  = {1'b0, cnt} + 9'd1;
    idx      = '0;
    over     = 1'b0;
    done     = 1'b0;
    cnt_next = '0;
    phase_next = ph;
    unique case (ph)
      FC_HDR_EXT_LEN: begin
        over       = byte_data > BYTE_W'(MaxHeaderExtra);
        phase_next = FC_ID;
      end
      FC_ID: begin
        idx = cnt;
        if (cnt_inc >= 9'(IdBytes)) begin
          phase_next = FC_ADDR;
        end else begin
          cnt_next = cnt_inc[IDX_W-1:0];
        end
      end
      FC_ADDR: begin
        idx = cnt;
        if (cnt_inc >= 9'(AddrBytes)) begin
          phase_next = FC_PORT;
        end else begin
          cnt_next = cnt_inc[IDX_W-1:0];
        end
      end
      FC_PORT: begin
        idx = cnt;
        if (cnt_inc >= 9'(PortBytes)) begin
          phase_next = (hdr_ext_len != '0) ? FC_HDR_EXT : FC_CTX_TYPE;
        end else begin
          cnt_next = cnt_inc[IDX_W-1:0];
        end
      end
      FC_HDR_EXT: begin
        idx = cnt;
        if (cnt_inc >= {1'b0, hdr_ext_len}) begin
          phase_next = FC_CTX_TYPE;
        end else begin
          cnt_next = cnt_inc[IDX_W-1:0];
        end
      end
      FC_BRICK_CNT: begin
        over       = byte_data > BYTE_W'(MaxBricks);
        phase_next = (byte_data != '0) ? FC_BRICK_CTX : FC_DATA_TYPE;
      end
      FC_BRICK_CTX: begin
        idx        = cnt;
        cnt_next   = cnt;
        phase_next = FC_BRICK_MASK;
      end
      FC_BRICK_MASK: begin
        idx = cnt;
        if (cnt_inc >= {1'b0, brick_total}) begin
          phase_next = FC_DATA_TYPE;
        end else begin
          phase_next = FC_BRICK_CTX;
          cnt_next   = cnt_inc[IDX_W-1:0];
        end
      end
      FC_DATA: begin
        idx = cnt;
        if (cnt_inc >= 9'(DataBytes)) begin
          phase_next = FC_DATA_EXT_LEN;
        end else begin
          cnt_next = cnt_inc[IDX_W-1:0];
        end
      end
      FC_DATA_EXT_LEN: begin
        over = byte_data > BYTE_W'(MaxDataExtra);
        if (byte_data == '0) begin
          done = 1'b1;
        end else begin
          phase_next = FC_DATA_EXT;
        end
      end
      FC_DATA_EXT: begin
        idx = cnt;
        if (cnt_inc >= {1'b0, data_ext_len}) begin
          done = 1'b1;
        end else begin
          cnt_next = cnt_inc[IDX_W-1:0];
        end
      end
      default: begin
        // single-word fields step to the next code
        phase_next = ph + 5'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= FC_SERVICE;
      cnt          <= '0;
      hdr_ext_len  <= '0;
      brick_total  <= '0;
      data_ext_len <= '0;
      offset       <= '0;
    end else if (byte_take) begin
      if (done) begin
        phase  <= FC_SERVICE;
        cnt    <= '0;
        offset <= '0;
      end else begin
        phase  <= phase_next;
        cnt    <= cnt_next;
        offset <= offset + 11'd1;
      end
      if (ph == FC_HDR_EXT_LEN) begin
        hdr_ext_len <= byte_data;
      end
      if (ph == FC_BRICK_CNT) begin
        brick_total <= byte_data;
      end
      if (ph == FC_DATA_EXT_LEN) begin
        data_ext_len <= byte_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || res_ready) begin
      res_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take) begin
      res.field_code      <= ph;
      res.field_index     <= idx;
      res.byte_value      <= byte_data;
      res.byte_offset     <= offset;
      res.packet_end      <= done;
      res.size_over_limit <= over;
    end
  end

  // end of packet only on a data-extra length or data-extra word
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.packet_end |->
      res.field_code == FC_DATA_EXT_LEN || res.field_code == FC_DATA_EXT)
    else $error("packet end on a field that cannot close a packet");

  // limit flag only on length words
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.size_over_limit |->
      res.field_code == FC_HDR_EXT_LEN || res.field_code == FC_BRICK_CNT ||
      res.field_code == FC_DATA_EXT_LEN)
    else $error("limit flag on a field that carries no length");

  // a closed packet restarts the parser
  assert property (@(posedge clk) disable iff (rst)
    byte_take && done |=> phase == FC_SERVICE && offset == '0 && cnt == '0)
    else $error("parser did not restart after packet end");

  // offset zero only at the service word
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.byte_offset == '0 |-> res.field_code == FC_SERVICE)
    else $error("packet start not tagged as service");

endmodule

`default_nettype wire

FILE: hdl/context_packet_deframer_top.sv
// Top level of the context packet deframer: input register feeding the parser.
// Depends on cpd_pkg, cpd_in_stage and cpd_parser.
//
//  channel  dir  fields
//  s_*      in   tdata[7:0] data_byte
//  m_*      out  tdata field_code/field_index/byte_value/byte_offset, tlast packet_end,
//                tuser size_over_limit
//
// One word per cycle sustained while m_tready stays high; an accepted word reaches the result
// through the input register and then the result register.
// Synchronous active-high reset returns the parser to the service field at offset zero.
// A stall on m_tready backs up through both registers; s_tready drops only when both
// hold a word and m_tready is low.
`default_nettype none

module context_packet_deframer_top
  import cpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [4:0] field_code, [12:5] field_index,
                                      // [20:13] byte_value, [31:21] byte_offset
  output logic             m_tlast,   // packet_end
  output logic             m_tuser    // size_over_limit
);

  logic              byte_valid;
  logic [BYTE_W-1:0] byte_data;
  logic              byte_take;
  result_t           res;

  cpd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .byte_take  (byte_take)
  );

  cpd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .byte_take  (byte_take),
    .res_valid  (m_tvalid),
    .res        (res),
    .res_ready  (m_tready)
  );

  assign m_tdata = {res.byte_offset, res.byte_value, res.field_index, res.field_code};
  assign m_tlast = res.packet_end;
  assign m_tuser = res.size_over_limit;

endmodule

`default_nettype wire
